/* design/hdlc_pkg.sv */
// ----------------------------------------------------------------------------
// HDLC deframer package
// Result kinds, field widths and the result record shared by the deframer.
// ----------------------------------------------------------------------------
package hdlc_pkg;

    localparam int unsigned KIND_W   = 3;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 10;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned MIN_W    = 10;

    localparam logic [BYTE_W-1:0] FLAG_BYTE     = 8'h7E;
    localparam logic [MIN_W-1:0]  MIN_RESET     = 10'd18;
    localparam logic [2:0]        ONES_STUFF    = 3'd5;
    localparam logic [CNT_W-1:0]  CNT_SAT       = 16'hFFFF;

    localparam logic [KIND_W-1:0] KIND_DATA     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SHORT    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STUFF    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [CNT_W-1:0]  stuffing_error_count;
        logic [CNT_W-1:0]  overflow_count;
        logic              last;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] data_byte;
        logic [KIND_W-1:0] kind;
    } t_result;

endpackage

/* design/hdlc_byte_deframer_destuffer_top.sv */
// ----------------------------------------------------------------------------
// HDLC byte deframer and bit de-stuffer
// Finds flags, removes stuffed zeros, packs frame bytes and reports frame ends.
// ----------------------------------------------------------------------------
// One received byte is taken per clock. The whole byte is de-stuffed in a
// single pass of logic and its results (none, one or two) go into a 4-entry
// result queue in the same cycle. s_axis_tready is high while the queue has
// room for two results, so with the output side draining every cycle the
// block runs at one byte per cycle; a byte that yields two results (a data
// byte followed by a stuffing abort) is sent out as two results in turn.
// The min_frame_bytes register is written through the cfg channel, which is
// always ready.
module hdlc_byte_deframer_destuffer_top #(
    parameter int unsigned MAX_FRAME_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] data_byte, [17:8] frame_length, [33:18] overflow_count,
    // [49:34] stuffing_error_count, [55:50] zero
    output logic [55:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data      // [9:0] min_frame_bytes
);

    localparam int unsigned BW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned LW = (BW > hdlc_pkg::LEN_W) ? BW : hdlc_pkg::LEN_W;
    localparam int unsigned QD = 4;
    localparam int unsigned QA = 2;

    logic [hdlc_pkg::MIN_W-1:0]  r_min;
    logic                        r_in_frame;
    logic [7:0]                  r_part;
    logic [2:0]                  r_bits;
    logic [2:0]                  r_ones;
    logic [BW-1:0]               r_bytes;
    logic [hdlc_pkg::CNT_W-1:0]  r_ovf;
    logic [hdlc_pkg::CNT_W-1:0]  r_stf;

    logic                        n_in_frame;
    logic [7:0]                  n_part;
    logic [2:0]                  n_bits;
    logic [2:0]                  n_ones;
    logic [BW-1:0]               n_bytes;
    logic [hdlc_pkg::CNT_W-1:0]  n_ovf;
    logic [hdlc_pkg::CNT_W-1:0]  n_stf;

    hdlc_pkg::t_result           res0;
    hdlc_pkg::t_result           res1;
    logic [1:0]                  res_n;

    hdlc_pkg::t_result           r_q [QD];
    logic [QA-1:0]               r_wr;
    logic [QA-1:0]               r_rd;
    logic [QA:0]                 r_cnt;

    logic                        in_acc;
    logic                        pop;
    hdlc_pkg::t_result           head;

    function automatic logic [hdlc_pkg::LEN_W-1:0] len_of(input logic [BW-1:0] b);
        logic [LW-1:0] w;
        w = LW'(b);
        return w[hdlc_pkg::LEN_W-1:0];
    endfunction

    // Whole-byte de-stuffing, bits LSB first
    always_comb begin
        logic                        stop;
        logic                        bit_v;
        hdlc_pkg::t_result           r;
        stop       = 1'b0;
        bit_v      = 1'b0;
        r          = '0;
        n_in_frame = r_in_frame;
        n_part     = r_part;
        n_bits     = r_bits;
        n_ones     = r_ones;
        n_bytes    = r_bytes;
        n_ovf      = r_ovf;
        n_stf      = r_stf;
        res0       = '0;
        res1       = '0;
        res_n      = 2'd0;

        if (s_axis_tdata == hdlc_pkg::FLAG_BYTE) begin
            if (r_in_frame) begin
                r.kind = (LW'(r_bytes) < LW'(r_min)) ? hdlc_pkg::KIND_SHORT
                                                      : hdlc_pkg::KIND_CLOSED;
                r.frame_length         = len_of(r_bytes);
                r.overflow_count       = r_ovf;
                r.stuffing_error_count = r_stf;
                res0  = r;
                res_n = 2'd1;
            end
            n_in_frame = 1'b1;
            n_part     = '0;
            n_bits     = '0;
            n_ones     = '0;
            n_bytes    = '0;
        end else if (r_in_frame) begin
            for (int b = 0; b < 8; b++) begin
                if (!stop) begin
                    bit_v = s_axis_tdata[b];
                    r     = '0;
                    if (n_ones == hdlc_pkg::ONES_STUFF) begin
                        if (!bit_v) begin
                            n_ones = '0;
                        end else begin
                            if (n_stf != hdlc_pkg::CNT_SAT) begin
                                n_stf = n_stf + 1'b1;
                            end
                            r.kind                 = hdlc_pkg::KIND_STUFF;
                            r.frame_length         = len_of(n_bytes);
                            r.overflow_count       = n_ovf;
                            r.stuffing_error_count = n_stf;
                            if (res_n == 2'd0) res0 = r;
                            else               res1 = r;
                            res_n      = res_n + 2'd1;
                            n_in_frame = 1'b0;
                            n_part     = '0;
                            n_bits     = '0;
                            n_ones     = '0;
                            n_bytes    = '0;
                            stop       = 1'b1;
                        end
                    end else begin
                        n_part[n_bits] = bit_v;
                        if (n_bits == 3'd7) begin
                            if (n_bytes >= BW'(MAX_FRAME_BYTES)) begin
                                if (n_ovf != hdlc_pkg::CNT_SAT) begin
                                    n_ovf = n_ovf + 1'b1;
                                end
                                r.kind = hdlc_pkg::KIND_OVERFLOW;
                                stop   = 1'b1;
                            end else begin
                                n_bytes     = n_bytes + 1'b1;
                                r.kind      = hdlc_pkg::KIND_DATA;
                                r.data_byte = n_part;
                            end
                            r.frame_length         = len_of(n_bytes);
                            r.overflow_count       = n_ovf;
                            r.stuffing_error_count = n_stf;
                            if (res_n == 2'd0) res0 = r;
                            else               res1 = r;
                            res_n  = res_n + 2'd1;
                            n_part = '0;
                            n_bits = '0;
                            if (stop) begin
                                n_in_frame = 1'b0;
                                n_ones     = '0;
                                n_bytes    = '0;
                            end
                        end else begin
                            n_bits = n_bits + 3'd1;
                        end
                        if (!stop) begin
                            n_ones = bit_v ? n_ones + 3'd1 : 3'd0;
                        end
                    end
                end
            end
        end
        res0.last = (res_n == 2'd1);
        res1.last = (res_n == 2'd2);
    end

    assign s_axis_tready = (r_cnt <= (QA+1)'(QD - 2));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min      <= hdlc_pkg::MIN_RESET;
            r_in_frame <= 1'b0;
            r_part     <= '0;
            r_bits     <= '0;
            r_ones     <= '0;
            r_bytes    <= '0;
            r_ovf      <= '0;
            r_stf      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_min <= i_cfg_data;
            end
            if (in_acc) begin
                r_in_frame <= n_in_frame;
                r_part     <= n_part;
                r_bits     <= n_bits;
                r_ones     <= n_ones;
                r_bytes    <= n_bytes;
                r_ovf      <= n_ovf;
                r_stf      <= n_stf;
            end
        end
    end

    // Result queue
    assign head  = r_q[r_rd];
    assign pop   = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (in_acc && res_n != 2'd0) begin
            r_q[r_wr] <= res0;
        end
        if (in_acc && res_n == 2'd2) begin
            r_q[r_wr + 1'b1] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (in_acc) begin
                r_wr <= r_wr + QA'(res_n);
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (in_acc ? (QA+1)'(res_n) : '0) - (QA+1)'(pop);
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = {6'd0, head.stuffing_error_count, head.overflow_count,
                            head.frame_length, head.data_byte};

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// HDLC deframer testbench
// Feeds received bytes into the deframer through the input stream and checks
// every result against a bit-level model of flag hunting, de-stuffing, byte
// packing, the length limit and the abort counters. It runs directed cases
// first, then one long frame up to the overflow abort, then random frame
// traffic under several idle patterns and thresholds.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned MAX_FRAME   = 512;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned MAX_REPORTS = 100;
    localparam int unsigned SETTLE_CYC  = 4;
    localparam int unsigned N_DIRECTED  = 22;
    // bits 3 and 7 clear: runs of ones stay short and the flag cannot appear
    localparam logic [7:0]  CLEAN_MASK  = 8'h77;

    localparam logic [7:0] STUFF_PATTERNS [4] = '{8'h1F, 8'hF8, 8'h3E, 8'h7C};
    localparam logic [7:0] DIRECTED [N_DIRECTED] = '{
        8'h55, 8'h7E, 8'h7E, 8'h00, 8'hFF, 8'hFF, 8'h7E, 8'h1F,
        8'hFF, 8'h7E, 8'h1F, 8'h7E, 8'hF8, 8'h00, 8'h80, 8'hFE,
        8'h7E, 8'hAA, 8'h55, 8'hCC, 8'h33, 8'h7E
    };

    typedef enum int unsigned {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    class t_deframe_scoreboard;
        logic [hdlc_pkg::MIN_W-1:0] min_len        = hdlc_pkg::MIN_RESET;
        bit                         in_frame       = 1'b0;
        logic [7:0]                 partial        = '0;
        int unsigned                bits_held      = 0;
        int unsigned                ones_seen      = 0;
        int unsigned                frame_bytes    = 0;
        logic [hdlc_pkg::CNT_W-1:0] overflow_total = '0;
        logic [hdlc_pkg::CNT_W-1:0] stuffing_total = '0;
        hdlc_pkg::t_result          expected_q[$];
        int unsigned                mismatches     = 0;
        int unsigned                frame_items    = 0;   // bytes not dropped in hunt mode

        function void set_min_len(logic [hdlc_pkg::MIN_W-1:0] v);
            min_len = v;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void clear_frame();
            partial     = '0;
            bits_held   = 0;
            ones_seen   = 0;
            frame_bytes = 0;
        endfunction

        function hdlc_pkg::t_result make_result(logic [hdlc_pkg::KIND_W-1:0] kind,
                                                logic [7:0] data);
            hdlc_pkg::t_result r;
            r.kind                 = kind;
            r.data_byte            = data;
            r.frame_length         = frame_bytes[hdlc_pkg::LEN_W-1:0];
            r.last                 = 1'b0;
            r.overflow_count       = overflow_total;
            r.stuffing_error_count = stuffing_total;
            return r;
        endfunction

        function void note_byte(logic [7:0] rx);
            hdlc_pkg::t_result res [2];
            int                n;
            logic              bitv;
            n = 0;
            if (rx == hdlc_pkg::FLAG_BYTE) begin
                frame_items++;
                if (in_frame) begin
                    res[n] = make_result((frame_bytes < min_len) ? hdlc_pkg::KIND_SHORT
                                                                 : hdlc_pkg::KIND_CLOSED,
                                         '0);
                    n++;
                end
                in_frame = 1'b1;
                clear_frame();
            end else if (in_frame) begin
                frame_items++;
                for (int i = 0; i < 8; i++) begin
                    bitv = rx[i];
                    if (ones_seen == hdlc_pkg::ONES_STUFF) begin
                        if (!bitv) begin
                            ones_seen = 0;   // stuffed zero
                            continue;
                        end
                        if (stuffing_total != hdlc_pkg::CNT_SAT) stuffing_total++;
                        res[n] = make_result(hdlc_pkg::KIND_STUFF, '0);
                        n++;
                        in_frame = 1'b0;
                        clear_frame();
                        break;
                    end
                    partial[bits_held] = bitv;
                    bits_held++;
                    if (bits_held == 8) begin
                        if (frame_bytes >= MAX_FRAME) begin
                            if (overflow_total != hdlc_pkg::CNT_SAT) overflow_total++;
                            res[n] = make_result(hdlc_pkg::KIND_OVERFLOW, '0);
                            n++;
                            in_frame = 1'b0;
                            clear_frame();
                            break;
                        end
                        frame_bytes++;
                        res[n] = make_result(hdlc_pkg::KIND_DATA, partial);
                        n++;
                        partial   = '0;
                        bits_held = 0;
                    end
                    ones_seen = bitv ? ones_seen + 1 : 0;
                end
            end
            if (n > 0) res[n-1].last = 1'b1;
            for (int i = 0; i < n; i++) expected_q.push_back(res[i]);
        endfunction

        function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (want_v !== got_v) begin
                if (mismatches < MAX_REPORTS)
                    $error("%s: expected %0d, got %0d", name, want_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_result(hdlc_pkg::t_result got);
            hdlc_pkg::t_result want;
            if (expected_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $error("result with nothing expected: kind %0d", got.kind);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
            compare_field("frame_length", 32'(want.frame_length), 32'(got.frame_length));
            compare_field("last", 32'(want.last), 32'(got.last));
            compare_field("overflow_count", 32'(want.overflow_count),
                          32'(got.overflow_count));
            compare_field("stuffing_error_count", 32'(want.stuffing_error_count),
                          32'(got.stuffing_error_count));
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [9:0]  i_cfg_data    = '0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;

    t_deframe_scoreboard sb;

    hdlc_byte_deframer_destuffer_top #(
        .MAX_FRAME_BYTES(MAX_FRAME)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // all handshakes are sampled here, inputs noted before results are checked
    always @(posedge i_clk) begin
        hdlc_pkg::t_result got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
            if (i_cfg_valid && o_cfg_ready) sb.set_min_len(i_cfg_data);
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind                 = m_axis_tuser;
                got.data_byte            = m_axis_tdata[7:0];
                got.frame_length         = m_axis_tdata[17:8];
                got.overflow_count       = m_axis_tdata[33:18];
                got.stuffing_error_count = m_axis_tdata[49:34];
                got.last                 = m_axis_tlast;
                sb.check_result(got);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL hdlc_byte_deframer_destuffer_top");
                $finish;
            end
        end
    end

    function automatic logic [7:0] clean_byte();
        return 8'($urandom_range(255)) & CLEAN_MASK;
    endfunction

    // style 0: clean, 1: raw random, 2: clean mixed with stuffed-zero patterns and raw random bytes
    function automatic logic [7:0] frame_content(int unsigned style);
        int unsigned r;
        r = $urandom_range(99);
        case (style)
            0: return clean_byte();
            1: return 8'($urandom_range(255));
            default: begin
                if (r < 70) return clean_byte();
                if (r < 85) return STUFF_PATTERNS[$urandom_range(3)];
                return 8'($urandom_range(255));
            end
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] rx);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = rx;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_min_len(input logic [hdlc_pkg::MIN_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default:   begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
    endtask

    // frames separated by shared flags, with some line noise in between
    task automatic random_traffic(input int unsigned n_items);
        int unsigned goal;
        int unsigned body_len;
        int unsigned r;
        int unsigned style;
        goal = sb.frame_items + n_items;
        while (sb.frame_items < goal) begin
            if ($urandom_range(99) < 10) begin
                push_byte(8'($urandom_range(255)));
            end else begin
                body_len = ($urandom_range(9) == 0) ? $urandom_range(25, 40)
                                                    : $urandom_range(0, 22);
                r = $urandom_range(99);
                style = (r < 55) ? 2 : (r < 85) ? 0 : 1;
                push_byte(hdlc_pkg::FLAG_BYTE);
                repeat (body_len) push_byte(frame_content(style));
            end
        end
    endtask

    initial begin
        logic [hdlc_pkg::MIN_W-1:0] min_len;
        sb = new;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed cases under the reset threshold
        for (int k = 0; k < N_DIRECTED; k++) push_byte(DIRECTED[k]);
        settle();

        // a frame that fills up to the limit and then runs past it
        write_min_len(10'(MAX_FRAME));
        push_byte(hdlc_pkg::FLAG_BYTE);
        repeat (MAX_FRAME + 1) push_byte(clean_byte());
        settle();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: min_len = '0;
                1: min_len = 10'd1;
                2: min_len = 10'd1023;
                3: min_len = hdlc_pkg::MIN_RESET;
                4: min_len = 10'd512;
                5: min_len = 10'd5;
                6: min_len = 10'($urandom_range(2, 30));
                default: min_len = 10'd20;
            endcase
            set_idling(t_idle_mode'(p % 4));
            write_min_len(min_len);
            random_traffic(6);
            settle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS hdlc_byte_deframer_destuffer_top");
        else
            $display("FAIL hdlc_byte_deframer_destuffer_top");
        $finish;
    end

endmodule
